FILE: design/png_scanline_unfilter_assert.svh
// ----------------------------------------------------------------------------
// Scanline unfilter assertion macros
// Concurrent checks clocked on clk and disabled while arst_n is low.
// Define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SLU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scanline unfilter check failed");
`define SLU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scanline unfilter check failed");
`else
`define SLU_ASSERT_IMP(lbl, ante, cons)
`define SLU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/slu_pkg.sv
// ----------------------------------------------------------------------------
// Scanline unfilter package
// Filter codes, register indexes, word types and the Paeth predictor.
// ----------------------------------------------------------------------------
package slu_pkg;

	localparam int RB_W       = 14;
	localparam int BPP_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;
	localparam int HIST_DEPTH = 4;
	localparam int HIST_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BPP       = 1'd1;

	localparam logic [2:0] MODE_NONE  = 3'd0;
	localparam logic [2:0] MODE_SUB   = 3'd1;
	localparam logic [2:0] MODE_UP    = 3'd2;
	localparam logic [2:0] MODE_AVG   = 3'd3;
	localparam logic [2:0] MODE_PAETH = 3'd4;
	localparam logic [2:0] MODE_BAD   = 3'd5;

	localparam logic [7:0] MAX_FILTER_CODE = 8'd4;

	typedef struct packed {
		logic [7:0] data;
		logic [2:0] mode;
		logic       up_zero;
		logic       last;
	} slu_item_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] sa;
		logic signed [10:0] sb;
		logic signed [10:0] sc;
		logic signed [10:0] pa;
		logic signed [10:0] pb;
		logic signed [10:0] pc;
		logic [7:0] pick;
		sa = signed'({3'b000, a});
		sb = signed'({3'b000, b});
		sc = signed'({3'b000, c});
		pa = sb - sc;
		pb = sa - sc;
		pc = sa + sb - sc - sc;
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) pick = a;
		else if (pb <= pc) pick = b;
		else pick = c;
		return pick;
	endfunction

endpackage

FILE: design/slu_stream_if.sv
// ----------------------------------------------------------------------------
// Scanline unfilter stream interfaces
// Valid/ready channels for filtered input words and reconstructed words.
// ----------------------------------------------------------------------------
interface slu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_image;

	modport source(output valid, output data_byte, output start_image, input ready);
	modport sink(input valid, input data_byte, input start_image, output ready);
endinterface

interface slu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       last_in_row;
	logic       bad_filter;

	modport source(output valid, output pixel_byte, output last_in_row,
		output bad_filter, input ready);
	modport sink(input valid, input pixel_byte, input last_in_row,
		input bad_filter, output ready);
endinterface

FILE: design/slu_row_mem.sv
// ----------------------------------------------------------------------------
// Previous-row store
// Single-port-write, single-port-read memory with registered read data.
// ----------------------------------------------------------------------------
module slu_row_mem #(
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0]               rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [7:0]               wr_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: design/slu_recon.sv
// ----------------------------------------------------------------------------
// Reconstruction stage
// Applies the row filter to one word, keeps left and above-left history,
// writes the row store and drives the output register.
// ----------------------------------------------------------------------------
`include "png_scanline_unfilter_assert.svh"

module slu_recon #(
	parameter int ADDR_W = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push_valid,
	input  slu_pkg::slu_item_t              push_item,
	input  logic [ADDR_W-1:0]               push_col,
	input  logic                            hist_clr,
	input  logic [slu_pkg::HIST_IDX_W-1:0]  bpp_idx,
	input  logic [7:0]                      up_byte,
	output logic                            take,
	output logic                            wr_en,
	output logic [ADDR_W-1:0]               wr_addr,
	output logic [7:0]                      wr_data,
	slu_out_if.source                       dout
);

	logic               valid_s1;
	slu_pkg::slu_item_t item_s1;
	logic [ADDR_W-1:0]  col_s1;
	logic               out_valid_q;
	logic [7:0]         pixel_q;
	logic               last_q;
	logic               bad_q;
	logic [7:0]         left_q   [slu_pkg::HIST_DEPTH];
	logic [7:0]         upleft_q [slu_pkg::HIST_DEPTH];
	logic               s1_adv;
	logic [7:0]         left;
	logic [7:0]         upleft;
	logic [7:0]         up;
	logic [8:0]         sum;
	logic [7:0]         pred;
	logic [7:0]         res;

	assign s1_adv = valid_s1 && (!out_valid_q || dout.ready);
	assign take   = !valid_s1 || s1_adv;

	assign left   = left_q[bpp_idx];
	assign upleft = upleft_q[bpp_idx];
	assign up     = item_s1.up_zero ? 8'd0 : up_byte;
	assign sum    = {1'b0, left} + {1'b0, up};

	always_comb begin
		case (item_s1.mode)
			slu_pkg::MODE_SUB:   pred = left;
			slu_pkg::MODE_UP:    pred = up;
			slu_pkg::MODE_AVG:   pred = sum[8:1];
			slu_pkg::MODE_PAETH: pred = slu_pkg::paeth(left, up, upleft);
			default:             pred = 8'd0;
		endcase
	end

	assign res     = item_s1.data + pred;
	assign wr_en   = s1_adv;
	assign wr_addr = col_s1;
	assign wr_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && push_valid) begin
			item_s1 <= push_item;
			col_s1  <= push_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < slu_pkg::HIST_DEPTH; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (hist_clr) begin
			for (int k = 0; k < slu_pkg::HIST_DEPTH; k++) begin
				left_q[k]   <= 8'd0;
				upleft_q[k] <= 8'd0;
			end
		end else if (s1_adv) begin
			for (int k = slu_pkg::HIST_DEPTH - 1; k > 0; k--) begin
				left_q[k]   <= left_q[k-1];
				upleft_q[k] <= upleft_q[k-1];
			end
			left_q[0]   <= res;
			upleft_q[0] <= up;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_q <= res;
			last_q  <= item_s1.last;
			bad_q   <= (item_s1.mode == slu_pkg::MODE_BAD);
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.pixel_byte  = pixel_q;
	assign dout.last_in_row = last_q;
	assign dout.bad_filter  = bad_q;

	`SLU_ASSERT_IMP(a_push_room, push_valid, take)
	`SLU_ASSERT_IMP(a_clr_excl, hist_clr, !push_valid)
	`SLU_ASSERT_NXT(a_s1_hold, valid_s1 && !s1_adv, valid_s1 && $stable(item_s1))
	`SLU_ASSERT_NXT(a_out_src, !out_valid_q && !s1_adv, !out_valid_q)

endmodule

FILE: design/png_scanline_unfilter.sv
// ----------------------------------------------------------------------------
// Scanline unfilter top level
// An accepted word and its row store byte are registered, then feed the output register.
// Throughput: one word per cycle while dout.ready does not stall the output register;
// filter-type words give no output word.
// Reset: control, history and registers (row_bytes=1, bytes_per_pixel=1) clear at once;
// the row store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
	parameter int MAX_ROW_BYTES = 8192
) (
	input  logic                            clk,
	input  logic                            arst_n,
	slu_in_if.sink                          din,
	slu_out_if.source                       dout,
	input  logic                            cfg_we,
	input  logic [slu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [slu_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int ADDR_W = $clog2(MAX_ROW_BYTES);
	localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);
	localparam int LEN_W  = (CNT_W > slu_pkg::RB_W) ? CNT_W : slu_pkg::RB_W;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ROW_BYTES);

	logic [slu_pkg::RB_W-1:0]       row_bytes_q;
	logic [slu_pkg::BPP_W-1:0]      bpp_q;
	logic [ADDR_W-1:0]              column_q;
	logic [2:0]                     mode_q;
	logic                           awaiting_q;
	logic                           first_row_q;
	logic [LEN_W-1:0]               rb_ext;
	logic [LEN_W-1:0]               len_eff;
	logic [LEN_W-1:0]               col_next;
	logic [slu_pkg::HIST_IDX_W-1:0] bpp_idx;
	logic                           take;
	logic                           accept;
	logic                           is_mode;
	logic                           push_valid;
	logic                           hist_clr;
	logic                           last;
	slu_pkg::slu_item_t             push_item;
	logic [7:0]                     up_byte;
	logic                           wr_en;
	logic [ADDR_W-1:0]              wr_addr;
	logic [7:0]                     wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= slu_pkg::RB_W'(1);
			bpp_q       <= slu_pkg::BPP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				slu_pkg::CFG_ROW_BYTES: row_bytes_q <= cfg_data[slu_pkg::RB_W-1:0];
				slu_pkg::CFG_BPP:       bpp_q       <= cfg_data[slu_pkg::BPP_W-1:0];
			endcase
		end
	end

	assign rb_ext  = LEN_W'(row_bytes_q);
	assign len_eff = (rb_ext == '0) ? LEN_W'(1) : ((rb_ext > MAX_LEN) ? MAX_LEN : rb_ext);
	assign bpp_idx = (bpp_q == '0) ? 2'd0 :
		((bpp_q > 3'd4) ? 2'd3 : slu_pkg::HIST_IDX_W'(bpp_q - 3'd1));

	assign din.ready  = take;
	assign accept     = din.valid && take;
	assign is_mode    = din.start_image || awaiting_q;
	assign push_valid = accept && !is_mode;
	assign hist_clr   = accept && is_mode;
	assign col_next   = LEN_W'(column_q) + LEN_W'(1);
	assign last       = (col_next >= len_eff);

	assign push_item.data    = din.data_byte;
	assign push_item.mode    = mode_q;
	assign push_item.up_zero = first_row_q;
	assign push_item.last    = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			mode_q      <= slu_pkg::MODE_NONE;
			awaiting_q  <= 1'b1;
			first_row_q <= 1'b1;
		end else if (hist_clr) begin
			column_q   <= '0;
			awaiting_q <= 1'b0;
			mode_q     <= (din.data_byte > slu_pkg::MAX_FILTER_CODE) ?
				slu_pkg::MODE_BAD : din.data_byte[2:0];
			if (din.start_image) begin
				first_row_q <= 1'b1;
			end
		end else if (push_valid) begin
			if (last) begin
				column_q    <= '0;
				awaiting_q  <= 1'b1;
				first_row_q <= 1'b0;
			end else begin
				column_q <= col_next[ADDR_W-1:0];
			end
		end
	end

	slu_row_mem #(
		.DEPTH(MAX_ROW_BYTES)
	) u_row_mem (
		.clk    (clk),
		.rd_en  (push_valid),
		.rd_addr(column_q),
		.rd_data(up_byte),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	slu_recon #(
		.ADDR_W(ADDR_W)
	) u_recon (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_item (push_item),
		.push_col  (column_q),
		.hist_clr  (hist_clr),
		.bpp_idx   (bpp_idx),
		.up_byte   (up_byte),
		.take      (take),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.dout      (dout)
	);

endmodule
